// ----- hw/rtl/uasmd_pkg.sv -----
// ----------------------------------------------------------------------------
// uasmd_pkg
// Shared operation codes and control types of the unsigned arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uasmd_pkg;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_REM = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
    logic done;
  } uasmd_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/uasmd_seq.sv -----
// ----------------------------------------------------------------------------
// uasmd_seq
// Sequencer: counts the shift-add and restoring-division steps of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module uasmd_seq import uasmd_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  input  wire logic            in_b_zero,
  input  wire logic            out_free,
  output logic                 in_ready,
  output uasmd_ctrl_t          ctrl
);

  localparam int CW = $clog2(DATA_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          long_op;

  assign long_op = (in_op == OP_MUL) ||
                   (((in_op == OP_DIV) || (in_op == OP_REM)) && !in_b_zero);

  assign in_ready  = (state_r == ST_IDLE);
  assign ctrl.load = in_ready && in_valid;
  assign ctrl.step = (state_r == ST_RUN);
  assign ctrl.done = (state_r == ST_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = long_op ? ST_RUN : ST_FIN;
          cnt_nxt   = CW'(DATA_WIDTH - 1);
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uasmd_dp.sv -----
// ----------------------------------------------------------------------------
// uasmd_dp
// Datapath: shared adder-subtractor with accumulator and shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module uasmd_dp import uasmd_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire uasmd_ctrl_t           ctrl,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [DATA_WIDTH-1:0] in_a,
  input  wire logic [DATA_WIDTH-1:0] in_b,
  output logic [DATA_WIDTH-1:0]      res,
  output logic                       ovf,
  output logic                       dz
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = DATA_WIDTH + 2;

  logic [OP_W-1:0] op_r;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    mq_r, mq_nxt;
  logic [W-1:0]    b_r;
  logic            dz_r;

  logic            is_div, do_sub, b_zero, in_div;
  logic [AW-1:0]   x, y, sum;
  logic [W:0]      mul_t;

  assign is_div = (op_r == OP_DIV) || (op_r == OP_REM);
  assign do_sub = is_div || (op_r == OP_SUB);
  assign x      = is_div ? {1'b0, acc_r, mq_r[W-1]} : {2'b00, acc_r};
  assign y      = {2'b00, b_r};
  assign sum    = do_sub ? (x - y) : (x + y);
  assign mul_t  = mq_r[0] ? sum[W:0] : {1'b0, acc_r};

  assign b_zero = (in_b == '0);
  assign in_div = (in_op == OP_DIV) || (in_op == OP_REM);

  always_comb begin
    acc_nxt = acc_r;
    mq_nxt  = mq_r;
    if (is_div) begin
      if (!sum[AW-1]) begin
        acc_nxt = sum[W-1:0];
      end else begin
        acc_nxt = x[W-1:0];
      end
      mq_nxt = {mq_r[W-2:0], !sum[AW-1]};
    end else begin
      acc_nxt = mul_t[W:1];
      mq_nxt  = {mul_t[0], mq_r[W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r <= in_op;
      b_r  <= in_b;
      mq_r <= in_a;
      dz_r <= in_div && b_zero;
      if ((in_op == OP_MUL) || (in_div && !b_zero)) begin
        acc_r <= '0;
      end else begin
        acc_r <= in_a;
      end
    end else if (ctrl.step) begin
      acc_r <= acc_nxt;
      mq_r  <= mq_nxt;
    end
  end

  always_comb begin
    res = '0;
    ovf = 1'b0;
    dz  = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        res = sum[W-1:0];
        ovf = sum[W];
      end
      OP_SUB: begin
        res = sum[W-1:0];
        ovf = sum[AW-1];
      end
      OP_MUL: begin
        res = mq_r;
        ovf = |acc_r;
      end
      OP_DIV: begin
        res = dz_r ? '1 : mq_r;
        dz  = dz_r;
      end
      OP_REM: begin
        res = acc_r;
        dz  = dz_r;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/unsigned_add_sub_mul_div_unit.sv -----
// ----------------------------------------------------------------------------
// unsigned_add_sub_mul_div_unit
// Unsigned add, subtract, shift-add multiply and restoring divide/remainder.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata (low bit up)              tuser (low bit up)
// in_      slave      operand_a, operand_b            op
// out_     master     result                          overflow, divide_by_zero
//
// Add, subtract, zero-divisor and unused codes: no steps; the final state
// registers the result, and only then is the next word accepted.
// Multiply, divide, remainder: DATA_WIDTH steps of the shared adder-subtractor,
// then the final state as above; no new word is accepted before it.
// Synchronous active-low reset clears the sequencer and the output valid.
// in_tready is low while a word is at work; a stalled result holds the final state.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_add_sub_mul_div_unit import uasmd_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  localparam int IN_TW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,   // operand_a, operand_b
  input  wire logic [OP_W-1:0]   in_tuser,   // op
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_TW-1:0]      out_tdata,  // result
  output logic [1:0]             out_tuser   // overflow, divide_by_zero
);

  uasmd_ctrl_t           ctrl;
  logic [DATA_WIDTH-1:0] in_a, in_b, res;
  logic                  ovf, dz, out_free;
  logic                  out_valid_r;
  logic [OUT_TW-1:0]     out_data_r;
  logic [1:0]            out_user_r;

  assign in_a     = in_tdata[DATA_WIDTH-1:0];
  assign in_b     = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign out_free = !out_valid_r || out_tready;

  uasmd_seq #(.DATA_WIDTH(DATA_WIDTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_b_zero (in_b == '0),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .ctrl      (ctrl)
  );

  uasmd_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk   (clk),
    .ctrl  (ctrl),
    .in_op (in_tuser),
    .in_a  (in_a),
    .in_b  (in_b),
    .res   (res),
    .ovf   (ovf),
    .dz    (dz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_data_r <= OUT_TW'(res);
      out_user_r <= {dz, ovf};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.done |=> out_tvalid)
    else $error("result word not presented after completion");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> !in_tready)
    else $error("input accepted while a word is at work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("overflow and divide-by-zero raised together");

endmodule

`default_nettype wire

// ----- dv/unsigned_add_sub_mul_div_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_add_sub_mul_div_unit_tb
// Drives operation words into the arithmetic unit and checks every result
// word, field by field and in order, against the directed table's expected words or an in-bench arithmetic model.
// A short directed table comes first, then random words under several idling
// mixes, including one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module unsigned_add_sub_mul_div_unit_tb;
  import uasmd_pkg::*;

  localparam int DW = 32;
  localparam logic [OP_W-1:0] OP_RSV5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSV6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSV7 = 3'd7;
  localparam int RAND_PER_PHASE = 406;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 2 * DW;
  localparam logic [DW-1:0] ONES = '1;

  typedef struct packed {
    logic [DW-1:0] result;
    logic          overflow;
    logic          div_zero;
  } alu_word_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    logic            typed;
    alu_word_t       want;
  } op_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [2*DW-1:0]     in_tdata;   // operand_a, operand_b
  logic [OP_W-1:0]     in_tuser;   // op
  logic                out_tvalid;
  logic                out_tready;
  logic [DW-1:0]       out_tdata;  // result
  logic [1:0]          out_tuser;  // overflow, divide_by_zero

  alu_word_t pending_words[$];
  int        err_count;
  int        snd_idle_pct;
  int        rcv_stall_pct;
  int        hold_left;

  op_row_t op_rows [0:24] = '{
    '{OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFE, 1'b1, 1'b0}},
    '{OP_SUB, 32'h0000_0000, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{OP_SUB, 32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_SUB, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 1'b1, 1'b0}},
    '{OP_MUL, 32'h0001_0000, 32'h0001_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{OP_MUL, 32'h0000_FFFF, 32'h0001_0001, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{OP_MUL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_DIV, 32'h0000_1234, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1}},
    '{OP_REM, 32'h0000_1234, 32'h0000_0000, 1'b1, '{32'h0000_1234, 1'b0, 1'b1}},
    '{OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{OP_REM, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_DIV, 32'h0000_0007, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_REM, 32'h0000_0007, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0007, 1'b0, 1'b0}},
    '{OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
    '{OP_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1}},
    '{OP_REM, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{OP_RSV5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_RSV6, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_RSV7, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_DIV, 32'd100, 32'd7, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{OP_REM, 32'd100, 32'd7, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{OP_MUL, 32'd12345, 32'd6789, 1'b0, '{32'h0, 1'b0, 1'b0}}
  };

  unsigned_add_sub_mul_div_unit #(.DATA_WIDTH(DW)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic alu_word_t compute_alu_word(logic [OP_W-1:0] op, logic [DW-1:0] a,
                                                 logic [DW-1:0] b);
    alu_word_t   w;
    logic [DW:0] sum;
    logic [2*DW-1:0] prod;
    w = '0;
    case (op)
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        w.result = sum[DW-1:0];
        w.overflow = sum[DW];
      end
      OP_SUB: begin
        w.result = a - b;
        w.overflow = (b > a);
      end
      OP_MUL: begin
        prod = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
        w.result = prod[DW-1:0];
        w.overflow = |prod[2*DW-1:DW];
      end
      OP_DIV: begin
        if (b == '0) begin
          w.result = ONES;
          w.div_zero = 1'b1;
        end else begin
          w.result = a / b;
        end
      end
      OP_REM: begin
        if (b == '0) begin
          w.result = a;
          w.div_zero = 1'b1;
        end else begin
          w.result = a % b;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [DW-1:0] pick_operand();
    int k;
    k = $urandom_range(0, DW - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return ONES;
      3: return ONES << k;
      4: return $urandom_range(0, 255);
      5: return ONES >> k;
      6: return (ONES >> k) & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    logic [OP_W-1:0] op;
    if ($urandom_range(0, 99) < 92) op = OP_W'($urandom_range(OP_ADD, OP_REM));
    else op = OP_W'($urandom_range(OP_RSV5, OP_RSV7));
    return op;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Present one word, idling first at random; return on the accepting edge.
  task automatic send_word(logic [OP_W-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b,
                           alu_word_t want);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < snd_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    pending_words = {pending_words, want};
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    alu_word_t got;
    alu_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.result = out_tdata[DW-1:0];
        got.overflow = out_tuser[0];
        got.div_zero = out_tuser[1];
        if (pending_words.size() == 0) begin
          flag_error($sformatf("unexpected word result=%h", got.result));
        end else begin
          want = pending_words.pop_front();
          if (got.result !== want.result)
            flag_error($sformatf("result got %h want %h", got.result, want.result));
          if (got.overflow !== want.overflow)
            flag_error($sformatf("overflow got %b want %b", got.overflow, want.overflow));
          if (got.div_zero !== want.div_zero)
            flag_error($sformatf("divide_by_zero got %b want %b", got.div_zero,
                                 want.div_zero));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    op_row_t         row;
    err_count = 0;
    hold_left = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (op_rows[i]) begin
      row = op_rows[i];
      send_word(row.op, row.a, row.b,
                row.typed ? row.want : compute_alu_word(row.op, row.a, row.b));
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
        default: begin snd_idle_pct = 20; rcv_stall_pct = 20; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // back up the pipe: receiver holds off while words keep coming
        if (phase == 0 && n == 100) hold_left = HOLD_CYCLES;
        op = pick_op();
        a = pick_operand();
        b = pick_operand();
        send_word(op, a, b, compute_alu_word(op, a, b));
      end
    end
    in_tvalid <= 1'b0;

    while (pending_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/uasmd_pkg.sv
hw/rtl/uasmd_seq.sv
hw/rtl/uasmd_dp.sv
hw/rtl/unsigned_add_sub_mul_div_unit.sv
dv/unsigned_add_sub_mul_div_unit_tb.sv
